// ----- src/imusc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package imusc_pkg;

    // Item kinds carried in the input tuser
    typedef enum logic [1:0] {
        ACT_PROCESS  = 2'd0,
        ACT_CALIB    = 2'd1,
        ACT_LOAD     = 2'd2,
        ACT_RESERVED = 2'd3
    } t_action;

    // Configuration register indexes
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_ACCEL_BIAS_X = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ACCEL_BIAS_Y = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ACCEL_BIAS_Z = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_MAG_BIAS_X   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_MAG_BIAS_Y   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_MAG_BIAS_Z   = 3'd5;

    localparam int NUM_AXES = 3;
    localparam int SAMPLE_W = 32;

    // Filter and calibration coefficients at 30 fraction bits
    localparam longint B0_Q30 = 64'sd2071735500;
    localparam longint B1_Q30 = -64'sd1000494913;
    localparam longint B2_Q30 = 64'sd2501237;
    localparam longint K_Q30  = 64'sd322123;

    // Round a Q2.30 coefficient to frac fraction bits, half away from zero
    function automatic longint coef_round(input longint c30, input int frac);
        longint m;
        int     s;
        s = 30 - frac;
        m = (c30 < 0) ? -c30 : c30;
        if (s > 0) begin
            m = (m + (longint'(1) <<< (s - 1))) >>> s;
        end
        return (c30 < 0) ? -m : m;
    endfunction

    // Per-lane control for one transfer
    typedef struct packed {
        logic    take;
        t_action action;
        logic    primed;
    } t_lane_ctrl;

    // One axis worth of result fields
    typedef struct packed {
        logic [SAMPLE_W-1:0] bias;
        logic [SAMPLE_W-1:0] mag;
        logic [SAMPLE_W-1:0] accel;
        logic [SAMPLE_W-1:0] gyro;
    } t_lane_res;

endpackage

`default_nettype wire

// ----- src/imusc_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module imusc_lane
    import imusc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 30
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_lane_ctrl                 i_ctrl,
    input  wire logic signed [SAMPLE_W-1:0] i_gyro_raw,
    input  wire logic signed [SAMPLE_W:0]   i_gyro_rot,
    input  wire logic signed [SAMPLE_W:0]   i_accel_rot,
    input  wire logic signed [SAMPLE_W-1:0] i_mag,
    input  wire logic signed [SAMPLE_W-1:0] i_accel_bias,
    input  wire logic signed [SAMPLE_W-1:0] i_mag_bias,
    output t_lane_res                       o_res
);

    localparam logic signed [31:0] C_B0 = 32'(coef_round(B0_Q30, COEF_FRAC_BITS));
    localparam logic signed [31:0] C_B1 = 32'(coef_round(B1_Q30, COEF_FRAC_BITS));
    localparam logic signed [31:0] C_B2 = 32'(coef_round(B2_Q30, COEF_FRAC_BITS));
    localparam logic signed [31:0] C_K  = 32'(coef_round(K_Q30, COEF_FRAC_BITS));
    localparam logic signed [65:0] C_HALF = 66'sd1 <<< (COEF_FRAC_BITS - 1);

    function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    logic signed [SAMPLE_W-1:0] r_bias,  n_bias;
    logic signed [SAMPLE_W-1:0] r_older, n_older;
    logic signed [SAMPLE_W-1:0] r_newer, n_newer;

    logic signed [SAMPLE_W-1:0] ac, go, mo, y_filt, bias_cal;
    logic signed [63:0]         p0, p1, p2, pk, d;
    logic signed [65:0]         acc;

    // Bias correction, exact sums saturated back to 32 bits
    assign ac = sat32(66'(i_accel_rot) + 66'(i_accel_bias));
    assign go = sat32(66'(i_gyro_rot) + 66'(r_bias));
    assign mo = sat32(66'(i_mag) + 66'(i_mag_bias));

    // Filter step: three independent products, one sum, round, saturate
    assign p0     = 64'(r_newer) * 64'(C_B0);
    assign p1     = 64'(r_older) * 64'(C_B1);
    assign p2     = 64'(ac) * 64'(C_B2);
    assign acc    = 66'(p0) + 66'(p1) + 66'(p2) + C_HALF;
    assign y_filt = sat32(acc >>> COEF_FRAC_BITS);

    // Calibration: pull the bias against the corrected rate
    assign pk       = 64'(go) * 64'(C_K);
    assign d        = (pk + 64'(C_HALF)) >>> COEF_FRAC_BITS;
    assign bias_cal = sat32(66'(r_bias) - 66'(d));

    always_comb begin
        n_bias    = r_bias;
        n_older   = r_older;
        n_newer   = r_newer;
        o_res.gyro = '0;
        o_res.mag  = '0;
        case (i_ctrl.action)
            ACT_PROCESS, ACT_CALIB: begin
                if (i_ctrl.primed) begin
                    n_older = r_newer;
                    n_newer = y_filt;
                end else begin
                    n_older = ac;
                    n_newer = ac;
                end
                if (i_ctrl.action == ACT_CALIB) begin
                    n_bias = bias_cal;
                end
                o_res.gyro = go;
                o_res.mag  = mo;
            end
            ACT_LOAD: begin
                n_bias = i_gyro_raw;
            end
            default: begin
            end
        endcase
        o_res.accel = n_newer;
        o_res.bias  = n_bias;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias  <= '0;
            r_older <= '0;
            r_newer <= '0;
        end else if (i_ctrl.take) begin
            r_bias  <= n_bias;
            r_older <= n_older;
            r_newer <= n_newer;
        end
    end

endmodule

`default_nettype wire

// ----- src/imusc_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module imusc_merge
    import imusc_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_take,
    input  wire t_lane_res                    i_res [NUM_AXES],
    input  wire logic                         i_m_axis_tready,
    output logic                              o_m_axis_tvalid,
    output logic [4*NUM_AXES*SAMPLE_W-1:0]    o_m_axis_tdata,
    output logic                              o_ready
);

    localparam int GROUP_W = NUM_AXES * SAMPLE_W;

    logic                     r_valid, n_valid;
    logic [4*GROUP_W-1:0]     r_data,  n_data;

    assign o_ready = !r_valid || i_m_axis_tready;

    // Gather the lanes: gyro x..z, accel x..z, mag x..z, bias x..z
    always_comb begin
        n_data = r_data;
        if (i_take) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                n_data[0*GROUP_W + k*SAMPLE_W +: SAMPLE_W] = i_res[k].gyro;
                n_data[1*GROUP_W + k*SAMPLE_W +: SAMPLE_W] = i_res[k].accel;
                n_data[2*GROUP_W + k*SAMPLE_W +: SAMPLE_W] = i_res[k].mag;
                n_data[3*GROUP_W + k*SAMPLE_W +: SAMPLE_W] = i_res[k].bias;
            end
        end
    end

    assign n_valid = i_take || (r_valid && !i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;

endmodule

`default_nettype wire

// ----- src/imu_sample_conditioning_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// s_axis    in         tvalid / tready         tdata 288b sensor sample, tuser 2b action
// m_axis    out        tvalid / tready         tdata 384b conditioned sample and gyro bias
// cfg       in         we (no back-pressure)   addr 3b, wdata 32b accel / mag bias
//
// One sample per clock sustained when not back-pressured; each result is registered
// and appears in the cycle after its transfer. The rate is set by the accel filter
// recursion: each lane closes its multiply-add-round loop on its taps combinationally.
// The output register holds a result under back-pressure; a new sample is taken
// whenever that register is empty or being drained in the same cycle.
// Synchronous active-low reset clears biases, taps, the primed flag and valid.

module imu_sample_conditioning_core
    import imusc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 30
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // gyro_raw_x, gyro_raw_y, gyro_raw_z, accel_raw_x, accel_raw_y, accel_raw_z,
    // mag_raw_x, mag_raw_y, mag_raw_z (32b each, from bit 0 up)
    input  wire logic [287:0]          i_s_axis_tdata,
    // action
    input  wire logic [1:0]            i_s_axis_tuser,

    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // gyro_x_out, gyro_y_out, gyro_z_out, accel_x_filt, accel_y_filt, accel_z_filt,
    // mag_x_out, mag_y_out, mag_z_out, bias_x_now, bias_y_now, bias_z_now (32b each)
    output logic [383:0]               o_m_axis_tdata,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [SAMPLE_W-1:0]   i_cfg_wdata
);

    localparam int GROUP_W = NUM_AXES * SAMPLE_W;

    logic                       take;
    logic                       s_ready;
    t_action                    action;
    logic                       r_primed, n_primed;
    logic signed [SAMPLE_W-1:0] r_accel_bias [NUM_AXES];
    logic signed [SAMPLE_W-1:0] r_mag_bias   [NUM_AXES];

    logic signed [SAMPLE_W-1:0] gyro_raw  [NUM_AXES];
    logic signed [SAMPLE_W-1:0] accel_raw [NUM_AXES];
    logic signed [SAMPLE_W-1:0] mag_raw   [NUM_AXES];
    logic signed [SAMPLE_W:0]   gyro_rot  [NUM_AXES];
    logic signed [SAMPLE_W:0]   accel_rot [NUM_AXES];

    t_lane_ctrl                 lane_ctrl;
    t_lane_res                  lane_res [NUM_AXES];

    // A transfer happens whenever the output register can take its result
    assign o_s_axis_tready = s_ready;
    assign take            = i_s_axis_tvalid && s_ready;
    assign action          = t_action'(i_s_axis_tuser);

    // Unpack the sample, one 32-bit field per axis
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            gyro_raw[k]  = i_s_axis_tdata[0*GROUP_W + k*SAMPLE_W +: SAMPLE_W];
            accel_raw[k] = i_s_axis_tdata[1*GROUP_W + k*SAMPLE_W +: SAMPLE_W];
            mag_raw[k]   = i_s_axis_tdata[2*GROUP_W + k*SAMPLE_W +: SAMPLE_W];
        end
    end

    // Mounting rotation for gyro and accel: x' = -y, y' = x, z' = z.
    // One extra bit so that negating the most negative reading stays exact.
    assign gyro_rot[0]  = -(SAMPLE_W + 1)'(gyro_raw[1]);
    assign gyro_rot[1]  =  (SAMPLE_W + 1)'(gyro_raw[0]);
    assign gyro_rot[2]  =  (SAMPLE_W + 1)'(gyro_raw[2]);
    assign accel_rot[0] = -(SAMPLE_W + 1)'(accel_raw[1]);
    assign accel_rot[1] =  (SAMPLE_W + 1)'(accel_raw[0]);
    assign accel_rot[2] =  (SAMPLE_W + 1)'(accel_raw[2]);

    // First processed sample primes the filter taps of every lane
    assign n_primed = r_primed
                   || (take && (action == ACT_PROCESS || action == ACT_CALIB));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else begin
            r_primed <= n_primed;
        end
    end

    // Bias registers: writes outside the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_accel_bias[k] <= '0;
                r_mag_bias[k]   <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ACCEL_BIAS_X: r_accel_bias[0] <= i_cfg_wdata;
                CFG_ACCEL_BIAS_Y: r_accel_bias[1] <= i_cfg_wdata;
                CFG_ACCEL_BIAS_Z: r_accel_bias[2] <= i_cfg_wdata;
                CFG_MAG_BIAS_X:   r_mag_bias[0]   <= i_cfg_wdata;
                CFG_MAG_BIAS_Y:   r_mag_bias[1]   <= i_cfg_wdata;
                CFG_MAG_BIAS_Z:   r_mag_bias[2]   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign lane_ctrl.take   = take;
    assign lane_ctrl.action = action;
    assign lane_ctrl.primed = r_primed;

    // One lane per axis; each holds its own gyro bias and filter taps
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        imusc_lane #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (lane_ctrl),
            .i_gyro_raw   (gyro_raw[g]),
            .i_gyro_rot   (gyro_rot[g]),
            .i_accel_rot  (accel_rot[g]),
            .i_mag        (mag_raw[g]),
            .i_accel_bias (r_accel_bias[g]),
            .i_mag_bias   (r_mag_bias[g]),
            .o_res        (lane_res[g])
        );
    end

    // Merge the lane results into the output register
    imusc_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_res           (lane_res),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_ready         (s_ready)
    );

endmodule

`default_nettype wire

// ----- src/imusc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module imusc_checker
    import imusc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_s_axis_tvalid,
    input wire logic                o_s_axis_tready,
    input wire logic [287:0]        i_s_axis_tdata,
    input wire logic [1:0]          i_s_axis_tuser,
    input wire logic                o_m_axis_tvalid,
    input wire logic                i_m_axis_tready,
    input wire logic [383:0]        o_m_axis_tdata
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // An empty output stage never back-pressures the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // A bias load reports zero gyro and mag, and the loaded bias
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == ACT_LOAD
        |=> o_m_axis_tvalid && o_m_axis_tdata[95:0] == '0
            && o_m_axis_tdata[287:192] == '0
            && o_m_axis_tdata[383:288] == $past(i_s_axis_tdata[95:0]))
        else $error("bias load result wrong");

    // The unused action code reports zero gyro and mag
    a_idle_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == ACT_RESERVED
        |=> o_m_axis_tvalid && o_m_axis_tdata[95:0] == '0
            && o_m_axis_tdata[287:192] == '0)
        else $error("unused action produced sensor output");

endmodule

bind imu_sample_conditioning_core imusc_checker u_imusc_checker (.*);

`default_nettype wire
